// ----- rtl/i2c_master_bit_sequencer_assert.svh -----
// ----------------------------------------------------------------------------
// I2C master bit sequencer assertion macros
// Shared property forms for the sequencer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2CMS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/i2cms_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, request and result layouts and configuration constants.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_START    = 3'd1,
        CMD_STOP     = 3'd2,
        CMD_WRITE    = 3'd3,
        CMD_READ     = 3'd4,
        CMD_SEND_ACK = 3'd5,
        CMD_RECV_ACK = 3'd6
    } cmd_t;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_TICKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

    localparam logic [15:0] DELAY_TICKS_RESET = 16'd200;
    localparam logic [7:0]  ACK_TIMEOUT_RESET = 8'd250;

    // One input request, first field in the highest bits.
    typedef struct packed {
        logic       sda_in;
        logic       ack_level;
        logic [7:0] data;
        logic [2:0] func;
    } in_item_t;

    // One result, first field in the highest bits.
    typedef struct packed {
        logic       ack_status;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl;
    } result_t;

    localparam int unsigned IN_ITEM_W = $bits(in_item_t);
    localparam int unsigned RESULT_W  = $bits(result_t);

endpackage

// ----- rtl/i2c_master_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Tick-driven I2C master pin sequencer with a stream request/result interface.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one tick of the sequencer: it carries
// the sampled SDA level and, optionally, a command (start, stop, write byte,
// read byte, send ack, receive ack) that is taken only while no command is
// running. Every request yields exactly one result on the master stream with
// the driven SCL and SDA levels, busy and done flags, the last byte read and
// the last ack status. Every pin change or SDA sample is followed by
// delay_ticks hold ticks (register 0). Receive ack gives up after more than
// ack_timeout high samples (register 1), issues a stop and reports a nack.
// The block accepts one request per clock cycle while the result stream
// takes its results; a result held back there stalls new requests. A
// request is held in the request register, then goes through the sequencer
// step into the result register. The sequencer state is updated once per
// request, in that single step stage. Configuration writes are always accepted at once.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Request stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [2:0] func, [10:3] data, [11] ack_level, [12] sda_in, [15:13] zero
    input  logic [15:0]            s_tdata,
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] scl, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_data,
    // [12] ack_status, [15:13] zero
    output logic [15:0]            m_tdata,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

`include "i2c_master_bit_sequencer_assert.svh"

    logic [15:0] delay_ticks_reg;
    logic [7:0]  ack_timeout_reg;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;

    logic        out_free;
    logic        step_en;
    result_t     step_res;

    // Configuration registers; the user must write them only while the block is idle; not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg <= DELAY_TICKS_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DELAY_TICKS: delay_ticks_reg <= cfg_data;
                CFG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // The result register frees up when empty or when its result is taken,
    // so a request steps the sequencer whenever the result can be stored.
    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= in_item_t'(s_tdata[IN_ITEM_W-1:0]);
        end
    end

    i2cms_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .item        (in_item_reg),
        .delay_ticks (delay_ticks_reg),
        .ack_timeout (ack_timeout_reg),
        .result      (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - RESULT_W){1'b0}}, out_res_reg};

    // A completed command always leaves the sequencer idle.
    `I2CMS_ASSERT_SAME(a_done_not_busy, out_valid_reg && out_res_reg.done_res,
                       !out_res_reg.busy_res, "done result still reports busy")
    // Every sequencer step lands in the result register.
    `I2CMS_ASSERT_NEXT(a_step_to_out, step_en, out_valid_reg,
                       "sequencer step produced no result")
    // A request held back by a full result register is kept.
    `I2CMS_ASSERT_NEXT(a_req_held, in_valid_reg && !out_free, in_valid_reg,
                       "stalled request was lost")

endmodule

// ----- rtl/i2cms_core.sv -----
// ----------------------------------------------------------------------------
// I2C master bit sequencer core
// Holds the sequencer state and computes one tick's pin action and result.
// ----------------------------------------------------------------------------
module i2cms_core
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  in_item_t    item,
    input  logic [15:0] delay_ticks,
    input  logic [7:0]  ack_timeout,
    output result_t     result
);

    cmd_t        cmd_reg,       cmd_next;
    logic [4:0]  phase_reg,     phase_next;
    logic [3:0]  bit_cnt_reg,   bit_cnt_next;
    logic [7:0]  shift_reg,     shift_next;
    logic [15:0] delay_cnt_reg, delay_cnt_next;
    logic [7:0]  ack_wait_reg,  ack_wait_next;
    logic        scl_reg,       scl_next;
    logic        sda_reg,       sda_next;
    logic [7:0]  rx_byte_reg,   rx_byte_next;
    logic        ack_res_reg,   ack_res_next;

    logic        run;
    logic        finish;
    logic        done;
    logic [4:0]  cur_phase;
    logic [8:0]  ack_wait_inc;

    always_comb
    begin
        cmd_next       = cmd_reg;
        phase_next     = phase_reg;
        bit_cnt_next   = bit_cnt_reg;
        shift_next     = shift_reg;
        delay_cnt_next = delay_cnt_reg;
        ack_wait_next  = ack_wait_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        rx_byte_next   = rx_byte_reg;
        ack_res_next   = ack_res_reg;
        run            = 1'b0;
        finish         = 1'b0;
        done           = 1'b0;
        cur_phase      = '0;
        ack_wait_inc   = '0;

        if (cmd_reg == CMD_NONE)
        begin
            // A command is taken only while idle; unused codes are ignored.
            if ((item.func != CMD_NONE) && (item.func <= CMD_RECV_ACK))
            begin
                cmd_next      = cmd_t'(item.func);
                phase_next    = '0;
                bit_cnt_next  = '0;
                shift_next    = (item.func == CMD_WRITE) ? item.data : 8'd0;
                ack_wait_next = '0;
                run           = 1'b1;
            end
        end
        else if (delay_cnt_reg != 16'd0)
        begin
            delay_cnt_next = delay_cnt_reg - 16'd1;
        end
        else
        begin
            run = 1'b1;
        end

        if (run)
        begin
            cur_phase  = phase_next;
            phase_next = cur_phase + 5'd1;
            unique case (cmd_next)
                CMD_START:
                begin
                    case (cur_phase)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    sda_next = 1'b0;
                        5'd3:    scl_next = 1'b0;
                        default: finish = 1'b1;
                    endcase
                end
                CMD_STOP:
                begin
                    case (cur_phase)
                        5'd0:    sda_next = 1'b0;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    sda_next = 1'b1;
                        default: finish = 1'b1;
                    endcase
                end
                CMD_WRITE:
                begin
                    case (cur_phase)
                        5'd0:    sda_next = shift_next[7];
                        5'd1:    scl_next = 1'b1;
                        5'd2:
                        begin
                            scl_next     = 1'b0;
                            shift_next   = {shift_next[6:0], 1'b0};
                            bit_cnt_next = bit_cnt_next + 4'd1;
                            if (bit_cnt_next < 4'd8)
                            begin
                                phase_next = 5'd0;
                            end
                        end
                        5'd3:    sda_next = 1'b1;
                        5'd4:    scl_next = 1'b1;
                        default: finish = 1'b1;
                    endcase
                end
                CMD_READ:
                begin
                    case (cur_phase)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    scl_next = 1'b1;
                        5'd3:    shift_next = {shift_next[6:0], item.sda_in};
                        5'd4:
                        begin
                            scl_next     = 1'b0;
                            bit_cnt_next = bit_cnt_next + 4'd1;
                            if (bit_cnt_next < 4'd8)
                            begin
                                phase_next = 5'd2;
                            end
                        end
                        default:
                        begin
                            rx_byte_next = shift_next;
                            finish       = 1'b1;
                        end
                    endcase
                end
                CMD_SEND_ACK:
                begin
                    case (cur_phase)
                        5'd0:    sda_next = item.ack_level;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    scl_next = 1'b0;
                        default: finish = 1'b1;
                    endcase
                end
                CMD_RECV_ACK:
                begin
                    case (cur_phase)
                        5'd0:    scl_next = 1'b1;
                        5'd1:
                        begin
                            // Low SDA is an ack; each high sample counts toward
                            // the timeout, which ends in a stop and a nack.
                            ack_wait_inc = {1'b0, ack_wait_next} + 9'd1;
                            if (!item.sda_in)
                            begin
                                phase_next = 5'd7;
                            end
                            else if (ack_wait_inc > {1'b0, ack_timeout})
                            begin
                                phase_next = 5'd2;
                            end
                            else
                            begin
                                ack_wait_next = ack_wait_inc[7:0];
                                phase_next    = 5'd1;
                            end
                        end
                        5'd2:    sda_next = 1'b0;
                        5'd3:    scl_next = 1'b1;
                        5'd4:    sda_next = 1'b1;
                        5'd5:    scl_next = 1'b0;
                        5'd6:
                        begin
                            ack_res_next = 1'b1;
                            finish       = 1'b1;
                        end
                        5'd7:    scl_next = 1'b0;
                        default:
                        begin
                            ack_res_next = 1'b0;
                            finish       = 1'b1;
                        end
                    endcase
                end
                default: finish = 1'b1;
            endcase

            if (finish)
            begin
                cmd_next       = CMD_NONE;
                phase_next     = '0;
                delay_cnt_next = '0;
                done           = 1'b1;
            end
            else
            begin
                delay_cnt_next = delay_ticks;
            end
        end
    end

    always_comb
    begin
        result.scl        = scl_next;
        result.sda_out    = sda_next;
        result.busy_res   = (cmd_next != CMD_NONE);
        result.done_res   = done;
        result.read_data  = rx_byte_next;
        result.ack_status = ack_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= CMD_NONE;
            phase_reg     <= '0;
            bit_cnt_reg   <= '0;
            shift_reg     <= '0;
            delay_cnt_reg <= '0;
            ack_wait_reg  <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            rx_byte_reg   <= '0;
            ack_res_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            cmd_reg       <= cmd_next;
            phase_reg     <= phase_next;
            bit_cnt_reg   <= bit_cnt_next;
            shift_reg     <= shift_next;
            delay_cnt_reg <= delay_cnt_next;
            ack_wait_reg  <= ack_wait_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            rx_byte_reg   <= rx_byte_next;
            ack_res_reg   <= ack_res_next;
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Feeds clock-tick requests with commands, data and sampled SDA levels, runs a
// cycle-exact model of the pin sequencer alongside the block, and compares
// every result field by field under several delay and ack-timeout settings
// and several patterns of request gaps and result back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import i2cms_pkg::*;

    // Command code that the block does not define; it must be ignored.
    localparam logic [2:0] FUNC_UNUSED = 3'd7;
    // Register indexes with no register behind them; writes must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    // Requests sent per random phase before the running command is let finish.
    localparam int REQS_PER_PHASE = 150;
    localparam int RANDOM_PHASES  = 8;
    // Ticks sent after the longest-hold stop; the hold is still counting down.
    localparam int HOLD_TICKS     = 8;
    // The final pause after the drain leaves some margin.
    localparam int DRAIN_PAUSE    = 10;
    localparam int MAX_PRINTS     = 100;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [15:0]            m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    i2c_master_bit_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Sequencer model. These variables mirror the block's registers; they are
    // advanced once for every request that the block accepts, in order.
    // ------------------------------------------------------------------------
    logic [15:0] hold_ticks;    // register 0
    logic [7:0]  ack_limit;     // register 1
    cmd_t        run_cmd;
    logic [4:0]  step_idx;
    logic [3:0]  bits_done;
    logic [7:0]  shreg;
    logic [15:0] hold_cnt;
    logic [7:0]  high_cnt;
    logic        scl_q;
    logic        sda_q;
    logic [7:0]  rx_byte;
    logic        nack_q;

    // Expected results, oldest first.
    result_t pin_forecast[$];

    int errs = 0;
    int send_gap_pct = 0;
    int sink_stall_pct = 0;

    function automatic void reset_sequencer();
        hold_ticks = DELAY_TICKS_RESET;
        ack_limit  = ACK_TIMEOUT_RESET;
        run_cmd    = CMD_NONE;
        step_idx   = '0;
        bits_done  = '0;
        shreg      = '0;
        hold_cnt   = '0;
        high_cnt   = '0;
        scl_q      = 1'b1;
        sda_q      = 1'b1;
        rx_byte    = '0;
        nack_q     = 1'b0;
    endfunction

    // Takes the pin action of the current step and moves to the next one.
    // Returns 1 once the running command has nothing left to do.
    function automatic bit apply_pin_action(logic ack_lvl, logic sda);
        logic [4:0] p;
        logic [8:0] n;
        p = step_idx;
        step_idx = p + 5'd1;
        case (run_cmd)
            CMD_START:
                case (p)
                    5'd0: sda_q = 1'b1;
                    5'd1: scl_q = 1'b1;
                    5'd2: sda_q = 1'b0;
                    5'd3: scl_q = 1'b0;
                    default: return 1'b1;
                endcase
            CMD_STOP:
                case (p)
                    5'd0: sda_q = 1'b0;
                    5'd1: scl_q = 1'b1;
                    5'd2: sda_q = 1'b1;
                    default: return 1'b1;
                endcase
            CMD_WRITE:
                case (p)
                    5'd0: sda_q = shreg[7];
                    5'd1: scl_q = 1'b1;
                    5'd2:
                    begin
                        scl_q = 1'b0;
                        shreg = {shreg[6:0], 1'b0};
                        bits_done = bits_done + 4'd1;
                        if (bits_done < 4'd8)
                            step_idx = 5'd0;
                    end
                    5'd3: sda_q = 1'b1;
                    5'd4: scl_q = 1'b1;
                    default: return 1'b1;
                endcase
            CMD_READ:
                case (p)
                    5'd0: sda_q = 1'b1;
                    5'd1: scl_q = 1'b1;
                    5'd2: scl_q = 1'b1;
                    5'd3: shreg = {shreg[6:0], sda};
                    5'd4:
                    begin
                        scl_q = 1'b0;
                        bits_done = bits_done + 4'd1;
                        if (bits_done < 4'd8)
                            step_idx = 5'd2;
                    end
                    default:
                    begin
                        rx_byte = shreg;
                        return 1'b1;
                    end
                endcase
            CMD_SEND_ACK:
                case (p)
                    5'd0: sda_q = ack_lvl;
                    5'd1: scl_q = 1'b1;
                    5'd2: scl_q = 1'b0;
                    default: return 1'b1;
                endcase
            CMD_RECV_ACK:
                case (p)
                    5'd0: scl_q = 1'b1;
                    5'd1:
                    begin
                        if (!sda)
                            step_idx = 5'd7;
                        else
                        begin
                            n = {1'b0, high_cnt} + 9'd1;
                            if (n > {1'b0, ack_limit})
                                step_idx = 5'd2;
                            else
                            begin
                                high_cnt = n[7:0];
                                step_idx = 5'd1;
                            end
                        end
                    end
                    // Gave up: a stop condition, then SCL low again.
                    5'd2: sda_q = 1'b0;
                    5'd3: scl_q = 1'b1;
                    5'd4: sda_q = 1'b1;
                    5'd5: scl_q = 1'b0;
                    5'd6:
                    begin
                        nack_q = 1'b1;
                        return 1'b1;
                    end
                    5'd7: scl_q = 1'b0;
                    default:
                    begin
                        nack_q = 1'b0;
                        return 1'b1;
                    end
                endcase
            default: return 1'b1;
        endcase
        return 1'b0;
    endfunction

    // One clock tick of the sequencer; gives the result the block must return.
    function automatic result_t tick_sequencer(in_item_t req);
        result_t res;
        bit      act;
        bit      done;
        act  = 1'b0;
        done = 1'b0;
        if (run_cmd == CMD_NONE)
        begin
            // A new command is taken only while idle; its first action is
            // taken on the same tick.
            if (req.func >= CMD_START && req.func <= CMD_RECV_ACK)
            begin
                run_cmd   = cmd_t'(req.func);
                step_idx  = '0;
                bits_done = '0;
                shreg     = (req.func == CMD_WRITE) ? req.data : 8'd0;
                high_cnt  = '0;
                act       = 1'b1;
            end
        end
        else if (hold_cnt != 16'd0)
            hold_cnt = hold_cnt - 16'd1;
        else
            act = 1'b1;

        if (act)
        begin
            if (apply_pin_action(req.ack_level, req.sda_in))
            begin
                run_cmd  = CMD_NONE;
                step_idx = '0;
                hold_cnt = '0;
                done     = 1'b1;
            end
            else
                hold_cnt = hold_ticks;
        end

        res.scl        = scl_q;
        res.sda_out    = sda_q;
        res.busy_res   = (run_cmd != CMD_NONE);
        res.done_res   = done;
        res.read_data  = rx_byte;
        res.ack_status = nack_q;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the check of every result
    // against the oldest expectation.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        errs++;
        if (errs <= MAX_PRINTS)
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what,
                     got, want);
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (pin_forecast.size() == 0)
                report_mismatch("unexpected result", int'(got), 0);
            else
            begin
                want = pin_forecast.pop_front();
                if (got.scl !== want.scl)
                    report_mismatch("scl", int'(got.scl), int'(want.scl));
                if (got.sda_out !== want.sda_out)
                    report_mismatch("sda_out", int'(got.sda_out), int'(want.sda_out));
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
                if (got.done_res !== want.done_res)
                    report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", int'(got.read_data),
                                    int'(want.read_data));
                if (got.ack_status !== want.ack_status)
                    report_mismatch("ack_status", int'(got.ack_status),
                                    int'(want.ack_status));
            end
        end
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------------

    // Sends one tick request. The sender may idle first; once the request is
    // taken the model advances and the expectation is queued. A typed
    // expectation, where given, stands in for the model's one.
    task automatic push_request(in_item_t req, bit typed, result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, req};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = tick_sequencer(req);
        pin_forecast.push_back(typed ? want : predicted);
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pin_forecast.size() != 0)
            @(posedge clk);
    endtask

    // Writes one register; only called while nothing is in flight.
    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DELAY_TICKS)
            hold_ticks = val;
        else if (idx == CFG_ACK_TIMEOUT)
            ack_limit = val[7:0];
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Directed plan. A row is either a register write or one tick request;
    // a tick row may then keep the bus ticking with no command until the
    // sequencer is idle again, holding SDA at the row's level.
    // ------------------------------------------------------------------------
    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  value;
        in_item_t               req;
        bit                     to_idle;
        bit                     typed;
        result_t                want;
    } plan_row_t;

    plan_row_t plan[$];

    function automatic void plan_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.value  = val;
        plan.push_back(r);
    endfunction

    function automatic void plan_tick(logic [2:0] func, logic [7:0] data, logic ack,
                                      logic sda, bit to_idle);
        plan_row_t r;
        r = '{default: '0};
        r.req.func      = func;
        r.req.data      = data;
        r.req.ack_level = ack;
        r.req.sda_in    = sda;
        r.to_idle       = to_idle;
        plan.push_back(r);
    endfunction

    // Attaches a typed expectation to the last tick row; no byte read and no
    // ack received yet wherever this is used.
    function automatic void expect_pins(logic scl, logic sda, logic busy, logic done);
        plan[$].typed = 1'b1;
        plan[$].want  = '{ack_status: 1'b0, read_data: 8'd0, done_res: done,
                          busy_res: busy, sda_out: sda, scl: scl};
    endfunction

    initial
    begin
        in_item_t req;
        int       reqs;
        int       sda_mode;
        int       roll;

        reset_sequencer();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight after reset the pins are released and nothing has run.
        plan_tick(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0);
        expect_pins(1'b1, 1'b1, 1'b0, 1'b0);
        // The undefined command code is ignored like no command.
        plan_tick(FUNC_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b0);
        expect_pins(1'b1, 1'b1, 1'b0, 1'b0);
        // No hold ticks: one pin action per tick.
        plan_cfg(CFG_DELAY_TICKS, 16'd0);
        plan_cfg(CFG_ACK_TIMEOUT, 16'd0);
        // Start condition, tick by tick; a stop issued while busy is ignored.
        plan_tick(CMD_START, 8'h00, 1'b0, 1'b0, 1'b0);
        expect_pins(1'b1, 1'b1, 1'b1, 1'b0);
        plan_tick(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
        expect_pins(1'b1, 1'b1, 1'b1, 1'b0);
        plan_tick(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0);
        expect_pins(1'b1, 1'b0, 1'b1, 1'b0);
        plan_tick(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0);
        expect_pins(1'b0, 1'b0, 1'b1, 1'b0);
        plan_tick(CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b0);
        expect_pins(1'b0, 1'b0, 1'b0, 1'b1);
        // Byte extremes on write and read, both ack levels.
        plan_tick(CMD_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1);
        plan_tick(CMD_WRITE, 8'h00, 1'b0, 1'b0, 1'b1);
        plan_tick(CMD_READ, 8'hFF, 1'b1, 1'b1, 1'b1);
        plan_tick(CMD_READ, 8'h00, 1'b0, 1'b0, 1'b1);
        plan_tick(CMD_SEND_ACK, 8'h00, 1'b1, 1'b0, 1'b1);
        plan_tick(CMD_SEND_ACK, 8'hFF, 1'b0, 1'b1, 1'b1);
        // Receive ack: a low sample acks; with no tolerance one high sample
        // gives up at once.
        plan_tick(CMD_RECV_ACK, 8'h00, 1'b0, 1'b0, 1'b1);
        plan_tick(CMD_RECV_ACK, 8'h00, 1'b0, 1'b1, 1'b1);
        // Largest tolerance: gives up only on the 256th high sample.
        plan_cfg(CFG_ACK_TIMEOUT, 16'd255);
        plan_tick(CMD_RECV_ACK, 8'h00, 1'b0, 1'b1, 1'b1);
        plan_tick(CMD_STOP, 8'h00, 1'b0, 1'b0, 1'b1);
        plan_cfg(CFG_DELAY_TICKS, 16'd1);
        plan_tick(CMD_WRITE, 8'hA5, 1'b0, 1'b0, 1'b1);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain_results();
                write_register(plan[i].idx, plan[i].value);
            end
            else
            begin
                push_request(plan[i].req, plan[i].typed, plan[i].want);
                if (plan[i].to_idle)
                begin
                    req = plan[i].req;
                    while (run_cmd != CMD_NONE)
                    begin
                        req.func      = CMD_NONE;
                        req.data      = 8'($urandom_range(0, 255));
                        req.ack_level = 1'($urandom_range(0, 1));
                        push_request(req, 1'b0, '0);
                    end
                end
            end
        end

        // Random phases. Each one sets the registers while the block is idle,
        // picks an idling pattern and then issues random commands until its
        // share of requests is sent and the last command has finished.
        // While a command runs, the bus keeps ticking, mostly with no command
        // and now and then with one that must be ignored.
        sda_mode = 0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0:
                begin
                    write_register(CFG_DELAY_TICKS, 16'd0);
                    write_register(CFG_ACK_TIMEOUT, 16'd255);
                end
                1:
                begin
                    write_register(CFG_DELAY_TICKS, 16'd1);
                    write_register(CFG_ACK_TIMEOUT, {8'hFF, 8'd0});
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        write_register(CFG_DELAY_TICKS, 16'($urandom_range(4, 12)));
                    else
                        write_register(CFG_DELAY_TICKS, 16'($urandom_range(0, 3)));
                    case ($urandom_range(0, 4))
                        0: write_register(CFG_ACK_TIMEOUT, {8'($urandom), 8'd0});
                        1: write_register(CFG_ACK_TIMEOUT, {8'($urandom), 8'd1});
                        2: write_register(CFG_ACK_TIMEOUT, {8'($urandom), 8'd255});
                        default:
                            write_register(CFG_ACK_TIMEOUT,
                                           {8'($urandom), 8'($urandom_range(2, 20))});
                    endcase
                    // Writes to indexes with no register behind them.
                    if ($urandom_range(0, 1) == 0)
                        write_register(CFG_SPARE_A, 16'($urandom));
                    else
                        write_register(CFG_SPARE_B, 16'($urandom));
                end
            endcase

            case (ph % 4)
                0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_gap_pct = 56; sink_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  sink_stall_pct = 56; end
                default: begin send_gap_pct = 17; sink_stall_pct = 17; end
            endcase

            reqs = 0;
            while ((reqs < REQS_PER_PHASE) || (run_cmd != CMD_NONE))
            begin
                req.data      = 8'($urandom_range(0, 255));
                req.ack_level = 1'($urandom_range(0, 1));
                if (run_cmd == CMD_NONE)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 85)
                    begin
                        req.func = 3'($urandom_range(CMD_START, CMD_RECV_ACK));
                        // The slave's SDA behavior for this command: noisy,
                        // held high, held low, or mostly high.
                        sda_mode = $urandom_range(0, 3);
                    end
                    else if (roll < 93)
                        req.func = FUNC_UNUSED;
                    else
                        req.func = CMD_NONE;
                end
                else if ($urandom_range(0, 9) == 0)
                    req.func = 3'($urandom_range(0, 7));
                else
                    req.func = CMD_NONE;
                case (sda_mode)
                    0: req.sda_in = 1'($urandom_range(0, 1));
                    1: req.sda_in = 1'b1;
                    2: req.sda_in = 1'b0;
                    default: req.sda_in = ($urandom_range(0, 9) != 0);
                endcase
                push_request(req, 1'b0, '0);
                reqs++;
            end
        end

        // Longest hold: a stop takes its first action, then the hold counter
        // starts from the top of its range and only counts down from there.
        drain_results();
        write_register(CFG_DELAY_TICKS, 16'hFFFF);
        req.func      = CMD_STOP;
        req.data      = 8'h00;
        req.ack_level = 1'b0;
        req.sda_in    = 1'b1;
        push_request(req, 1'b0, '0);
        req.func = CMD_NONE;
        repeat (HOLD_TICKS)
            push_request(req, 1'b0, '0);

        drain_results();
        repeat (DRAIN_PAUSE) @(posedge clk);
        if (errs == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: far beyond the slowest run the stimulus can produce.
    initial
    begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- i2c_master_bit_sequencer.f -----
+incdir+rtl
rtl/i2cms_pkg.sv
rtl/i2cms_core.sv
rtl/i2c_master_bit_sequencer.sv
sim/testbench.sv
